@@ src/grid_local_max_finder_assert.svh @@
// ---------------------------------------------------------------------------
// grid_local_max_finder assertion macros
// Concurrent check helpers for the local maximum finder.
// ---------------------------------------------------------------------------
`ifndef GRID_LOCAL_MAX_FINDER_ASSERT_SVH
`define GRID_LOCAL_MAX_FINDER_ASSERT_SVH

// same-cycle implication
`define GLMF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glmf assertion failed");

// next-cycle implication
`define GLMF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glmf assertion failed");

`endif

@@ src/glmf_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// glmf_pkg
// Shared constants and types for the grid local maximum finder.
// ---------------------------------------------------------------------------
package glmf_pkg;

  localparam int CFG_IDX_BITS    = 1;
  localparam int CFG_DATA_BITS   = 16;
  localparam int GRID_WIDTH_BITS = 11;
  localparam int ROW_BITS        = 16;
  localparam int PEAK_COL_BITS   = 10;

  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 1'd1;

  localparam logic [GRID_WIDTH_BITS-1:0] GRID_WIDTH_RST  = 11'd1024;
  localparam logic [ROW_BITS-1:0]        GRID_HEIGHT_RST = 16'd1024;

  typedef logic [ROW_BITS-1:0]      row_t;
  typedef logic [PEAK_COL_BITS-1:0] peak_col_t;

  // pending results of one beat: left-of-here, above, grid corner
  typedef struct packed {
    logic corner;
    logic above;
    logic left;
  } peak_flags_t;

endpackage

@@ src/glmf_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// glmf_if
// Handshake channels of the grid local maximum finder.
// ---------------------------------------------------------------------------
interface glmf_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface glmf_out_if;
  logic                              valid;
  logic                              ready;
  logic [glmf_pkg::ROW_BITS-1:0]      peak_row;
  logic [glmf_pkg::PEAK_COL_BITS-1:0] peak_col;
  logic                              last_of_item;

  modport source (output valid, output peak_row, output peak_col, output last_of_item,
                  input ready);
  modport sink   (input valid, input peak_row, input peak_col, input last_of_item,
                  output ready);
endinterface

interface glmf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [glmf_pkg::CFG_IDX_BITS-1:0]  index;
  logic [glmf_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/grid_local_max_finder.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_local_max_finder
// Streams a signed grid in raster order and reports four-neighbour peaks.
// ---------------------------------------------------------------------------
// Usage:
//   in_chan  : one sample per beat, raster order, row by row.
//   out_chan : row/column of each peak; last_of_item flags the final result
//              caused by one input beat (up to three per beat).
//   cfg_chan : index 0 = grid_width, index 1 = grid_height; always ready.
//              Write only while no results are pending.
// Latency: results of a beat are shown in the cycle after its acceptance.
// Throughput: one sample per cycle while each beat yields at most one peak
//   and out_chan.ready is high; a beat with more peaks holds the input until
//   the single-entry output port has drained the pending-result register to its last entry.
// Line stores are read one beat ahead at the next column and the one after,
//   so a sample is decided with no memory wait.
// Reset: counters, window and pending results clear, geometry returns to
//   1024 x 1024; line stores keep their contents.
// Stall: when out_chan.ready is low the pending results hold and in_chan
//   takes no sample while any result is pending.
// ---------------------------------------------------------------------------
module grid_local_max_finder #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  glmf_in_if.sink     in_chan,
  glmf_out_if.source  out_chan,
  glmf_cfg_if.sink    cfg_chan
);
  import glmf_pkg::*;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int LW_MAX   = $clog2(MAX_WIDTH + 1);
  localparam int LW       = (LW_MAX > GRID_WIDTH_BITS) ? LW_MAX : GRID_WIDTH_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  // configuration
  logic [GRID_WIDTH_BITS-1:0] grid_width_r;
  row_t                       grid_height_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_chan.data[GRID_WIDTH_BITS-1:0];
        REG_GRID_HEIGHT: grid_height_r <= cfg_chan.data[ROW_BITS-1:0];
      endcase
    end
  end

  // position and window state
  logic [COL_BITS-1:0] col_r, col_nxt;
  row_t                row_r, row_nxt;
  smp_t                ws0_r, ws1_r, ws2_r;
  peak_flags_t         pend_r, pend_nxt;
  row_t                pos_row_r;
  logic [COL_BITS-1:0] pos_col_r;

  logic [LW-1:0]       w_clip, w_eff;
  row_t                h_eff;
  logic                last_col, last_row;
  logic [COL_BITS-1:0] col_next_pos;
  smp_t                s, above, right, two;
  logic                in_fire, out_fire, pend_one;
  peak_flags_t         flags;

  assign w_clip = (grid_width_r < GRID_WIDTH_BITS'(2)) ? LW'(2) : LW'(grid_width_r);
  assign w_eff  = (w_clip > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : w_clip;
  assign h_eff  = (grid_height_r < ROW_BITS'(2)) ? ROW_BITS'(2) : grid_height_r;
  assign last_col = LW'(col_r) >= (w_eff - LW'(1));
  assign last_row = row_r >= (h_eff - ROW_BITS'(1));
  assign col_next_pos = last_col ? '0 : col_r + COL_BITS'(1);

  assign s = in_chan.sample;

  glmf_line_buf #(
    .DEPTH (MAX_WIDTH),
    .DW    (SAMPLE_BITS)
  ) u_line_buf (
    .clk      (clk),
    .we       (in_fire),
    .wa       (col_r),
    .wd_above (s),
    .wd_two   (above),
    .re       (in_fire),
    .ra0      (col_next_pos),
    .ra1      (col_next_pos + COL_BITS'(1)),
    .above0_r (above),
    .above1_r (right),
    .two0_r   (two)
  );

  // peak decisions for this beat
  always_comb begin
    flags.left = last_row && (col_r != '0)
                 && ((row_r == '0) || (ws0_r >= ws2_r))
                 && ((col_r <= COL_BITS'(1)) || (ws0_r >= ws1_r))
                 && (ws0_r >= s);
    flags.above = (row_r != '0)
                  && ((row_r < ROW_BITS'(2)) || (above >= two))
                  && (above >= s)
                  && ((col_r == '0) || (above >= ws2_r))
                  && (last_col || (above >= right));
    flags.corner = last_row && last_col
                   && ((row_r == '0) || (s >= above))
                   && ((col_r == '0) || (s >= ws0_r));
  end

  // handshake
  assign pend_one = (pend_r & (pend_r - 3'd1)) == '0;
  assign out_fire = out_chan.valid && out_chan.ready;
  assign in_chan.ready = (pend_r == '0) || (pend_one && out_chan.ready);
  assign in_fire = in_chan.valid && in_chan.ready;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (in_fire) begin
      col_nxt = col_next_pos;
      if (last_col) begin
        row_nxt = last_row ? '0 : row_r + ROW_BITS'(1);
      end
    end
    if (in_fire) begin
      pend_nxt = flags;
    end else if (out_fire) begin
      pend_nxt = pend_r & (pend_r - 3'd1);
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      ws0_r  <= '0;
      ws1_r  <= '0;
      ws2_r  <= '0;
      pend_r <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      pend_r <= pend_nxt;
      if (in_fire) begin
        ws1_r <= ws0_r;
        ws0_r <= s;
        ws2_r <= above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pos_row_r <= row_r;
      pos_col_r <= col_r;
    end
  end

  // result port: lowest pending flag first (left, then above, then corner)
  assign out_chan.valid        = pend_r != '0;
  assign out_chan.last_of_item = pend_one;
  assign out_chan.peak_row     = (!pend_r.left && pend_r.above) ? pos_row_r - ROW_BITS'(1)
                                                                : pos_row_r;
  assign out_chan.peak_col     = pend_r.left ? PEAK_COL_BITS'(pos_col_r - COL_BITS'(1))
                                             : PEAK_COL_BITS'(pos_col_r);

  `include "grid_local_max_finder_assert.svh"

  `GLMF_ASSERT_IMP(a_accept_drained, clk, rst_n, in_fire, (pend_r == '0) || (pend_one && out_fire))
  `GLMF_ASSERT_NXT(a_col_wrap, clk, rst_n, in_fire && last_col, col_r == '0)
  `GLMF_ASSERT_NXT(a_result_shown, clk, rst_n, in_fire && (flags != '0), out_chan.valid)

endmodule

@@ src/glmf_line_buf.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// glmf_line_buf
// Two line stores (previous row, row before) with registered, write-through
// reads; the previous row is read at two columns per beat.
// ---------------------------------------------------------------------------
module glmf_line_buf #(
  parameter int DEPTH = 1024,
  parameter int DW    = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [DW-1:0]            wd_above,
  input  logic [DW-1:0]            wd_two,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra0,
  input  logic [$clog2(DEPTH)-1:0] ra1,
  output logic [DW-1:0]            above0_r,
  output logic [DW-1:0]            above1_r,
  output logic [DW-1:0]            two0_r
);

  logic [DW-1:0] above_mem [DEPTH];
  logic [DW-1:0] two_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      above_mem[wa] <= wd_above;
      two_mem[wa]   <= wd_two;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      above0_r <= (we && (ra0 == wa)) ? wd_above : above_mem[ra0];
      above1_r <= (we && (ra1 == wa)) ? wd_above : above_mem[ra1];
      two0_r   <= (we && (ra0 == wa)) ? wd_two   : two_mem[ra0];
    end
  end

endmodule
